// ===== hdl/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the delta rule replay trainer
// Sizes, codes, sequencer states and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int IN_MAX    = 16;
  localparam int OUT_MAX   = 8;
  localparam int MEM_DEPTH = 16;
  localparam int IN_W      = $clog2(IN_MAX);
  localparam int OUT_W     = $clog2(OUT_MAX);
  localparam int MEM_W     = $clog2(MEM_DEPTH);
  localparam int W_AW      = OUT_W + IN_W;
  localparam int X_AW      = MEM_W + IN_W;
  localparam int T_AW      = MEM_W + OUT_W;

  // Sum of norms: up to MEM_DEPTH values below 2^32.
  localparam int DIV_W     = 37;
  localparam int DSR_W     = 5;
  localparam int ACC_W     = 37;

  localparam logic [16:0] ONE_Q      = 17'd65536;
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

  typedef enum logic [1:0] {
    FN_LOAD_IN  = 2'd0,
    FN_LOAD_TGT = 2'd1,
    FN_LOAD_QRY = 2'd2,
    FN_COMMIT   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    RG_RATE      = 3'd0,
    RG_SMOOTHING = 3'd1,
    RG_EPOCHS    = 3'd2,
    RG_IN_LEN    = 3'd3,
    RG_OUT_LEN   = 3'd4,
    RG_SLOTS     = 3'd5
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SLOT, ST_STORE, ST_FWD_RD, ST_FWD_MUL, ST_FWD_ACC, ST_DELTA,
    ST_MOM_A, ST_MOM_B, ST_MOM_C, ST_AM_MUL, ST_AM_LOAD, ST_UPD_RD,
    ST_UPD_MUL, ST_UPD_WR, ST_NORM_MUL, ST_NORM_ACC, ST_ROOT, ST_MEAN, ST_OUT
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  // Result of the shared divider.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/delta_rule_replay_trainer.sv =====
// Sequence: a commit stores the staged sample (in a random slot once the memory is full),
//   then for E > 0 epochs trains on every filled slot, runs the error pass and the mean,
//   and finally sends one result per output element, holding each one through any stall.
// Throughput: one item at a time; the single shared multiplier sets the commit time.
// Reset: asynchronous, active low; weights, vectors, fill count and LFSR are cleared
//   at once (weights through per-entry valid bits), so no clearing pass is needed.
// ----------------------------------------------------------------------------
// delta_rule_replay_trainer: linear associator trained by the delta rule
// Replay memory, momentum update, mean error measure and query output.
// ----------------------------------------------------------------------------
module delta_rule_replay_trainer import drt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input items.
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [39:0]   s_axis_tdata_i,  // elem[3:0], value[35:4], zero pad
  input  logic [1:0]    s_axis_tuser_i,  // func[1:0]
  // Result items.
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [103:0]  m_axis_tdata_o,  // out_elem, out_value, mean_error, confidence
  output logic          m_axis_tlast_o,
  // Configuration.
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // Configuration registers
  logic [16:0] rate_q, smooth_q;
  logic [3:0]  epochs_q, out_len_q;
  logic [4:0]  in_len_q, slots_q;
  logic        cfg_we;
  reg_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= 17'd6554;
      smooth_q  <= '0;
      epochs_q  <= 4'd1;
      in_len_q  <= 5'd16;
      out_len_q <= 4'd8;
      slots_q   <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_idx)
        RG_RATE:      rate_q    <= pwdata[16:0];
        RG_SMOOTHING: smooth_q  <= pwdata[16:0];
        RG_EPOCHS:    epochs_q  <= pwdata[3:0];
        RG_IN_LEN:    in_len_q  <= pwdata[4:0];
        RG_OUT_LEN:   out_len_q <= pwdata[3:0];
        RG_SLOTS:     slots_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RG_RATE:      prdata = 32'(rate_q);
      RG_SMOOTHING: prdata = 32'(smooth_q);
      RG_EPOCHS:    prdata = 32'(epochs_q);
      RG_IN_LEN:    prdata = 32'(in_len_q);
      RG_OUT_LEN:   prdata = 32'(out_len_q);
      RG_SLOTS:     prdata = 32'(slots_q);
      default:      prdata = '0;
    endcase
  end

  // Clamped register values
  logic [4:0]         ni, ns;
  logic [3:0]         no;
  logic signed [31:0] alpha, beta, one_m_beta;

  assign ni = (in_len_q == '0) ? 5'd1 : (in_len_q > 5'(IN_MAX)) ? 5'(IN_MAX) : in_len_q;
  assign no = (out_len_q == '0) ? 4'd1 :
              (out_len_q > 4'(OUT_MAX)) ? 4'(OUT_MAX) : out_len_q;
  assign ns = (slots_q == '0) ? 5'd1 :
              (slots_q > 5'(MEM_DEPTH)) ? 5'(MEM_DEPTH) : slots_q;
  assign alpha      = 32'((rate_q > ONE_Q) ? ONE_Q : rate_q);
  assign beta       = 32'((smooth_q > ONE_Q) ? ONE_Q : smooth_q);
  assign one_m_beta = 32'(ONE_Q) - beta;

  // Input fields
  func_e              in_func;
  logic [IN_W-1:0]    in_elem;
  logic signed [31:0] in_value;
  logic               in_acc;

  assign in_func  = func_e'(s_axis_tuser_i);
  assign in_elem  = s_axis_tdata_i[IN_W-1:0];
  assign in_value = s_axis_tdata_i[35:4];

  // Sequencer state and counters
  state_e             state_q, state_d;
  logic [IN_W-1:0]    i_q, i_d;
  logic [OUT_W-1:0]   j_q, j_d;
  logic [MEM_W-1:0]   m_q, m_d, slot_q, slot_d;
  logic [3:0]         e_q, e_d;
  logic [IN_W-1:0]    k_q, k_d;
  logic [4:0]         fill_q, fill_d;
  logic [15:0]        lfsr_q, lfsr_d;
  logic               meas_q, meas_d, omode_q, omode_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [31:0] tmp_q, tmp_d, am_q, am_d;
  logic [63:0]        sq_q, sq_d;
  logic [DIV_W-1:0]   esum_q, esum_d;
  logic [30:0]        err_q, err_d;
  logic               ov_q, ov_d, olast_q, olast_d;
  logic [OUT_W-1:0]   oel_q, oel_d;
  logic signed [31:0] oval_q, oval_d;

  // Small register files
  logic signed [31:0] stg_in_q  [IN_MAX];
  logic signed [31:0] stg_tg_q  [OUT_MAX];
  logic signed [31:0] qry_q     [IN_MAX];
  logic signed [31:0] mom_q     [OUT_MAX];
  logic signed [31:0] dlt_q     [OUT_MAX];
  logic               mom_we, dlt_we;
  logic signed [31:0] mom_wd, dlt_wd;

  // Memory ports
  logic               w_we, x_we, t_we;
  logic [W_AW-1:0]    w_addr;
  logic [X_AW-1:0]    x_waddr, x_raddr;
  logic [T_AW-1:0]    t_waddr, t_raddr;
  logic signed [31:0] w_wd, w_rd;
  logic signed [31:0] x_rd_q, t_rd_q, w_raw_q;
  logic               w_ok_q;
  logic [2**W_AW-1:0] wv_q;
  logic signed [31:0] wmem [2**W_AW];
  logic signed [31:0] xmem [2**X_AW];
  logic signed [31:0] tmem [2**T_AW];

  // Shared units
  logic signed [31:0] mul_a, mul_b, mul_q;
  logic signed [63:0] mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;

  drt_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p),
    .q_o    (mul_q)
  );

  drt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  drt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // Helper terms for the sequencer
  logic               last_i, last_j, last_m, last_e;
  logic [15:0]        lfsr_nx;
  logic signed [31:0] dot_o, dlt_new;
  logic [64:0]        sq_sum;
  logic [DIV_W-1:0]   esum_nx;
  logic               root_go_q;

  assign last_i  = ({1'b0, i_q} == ni - 5'd1);
  assign last_j  = ({1'b0, j_q} == no - 4'd1);
  assign last_m  = ({1'b0, m_q} + 5'd1 == fill_q);
  assign last_e  = (e_q + 4'd1 == epochs_q);
  assign lfsr_nx = lfsr_q[0] ? ({1'b0, lfsr_q[15:1]} ^ LFSR_TAPS) : {1'b0, lfsr_q[15:1]};
  assign dot_o   = sat32(48'(acc_q));
  assign dlt_new = sat32(48'(t_rd_q) - 48'(dot_o));
  assign sq_sum  = {1'b0, sq_q} + {1'b0, mul_p};
  assign esum_nx = esum_q + DIV_W'(sq_root);
  assign w_rd    = w_ok_q ? w_raw_q : '0;

  assign x_raddr = {m_q, i_q};
  assign t_raddr = {m_q, j_q};
  assign w_addr  = {j_q, i_q};
  assign x_waddr = {slot_q, k_q};
  assign t_waddr = {slot_q, k_q[OUT_W-1:0]};

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;

  // Next state and datapath control
  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    m_d      = m_q;
    slot_d   = slot_q;
    e_d      = e_q;
    k_d      = k_q;
    fill_d   = fill_q;
    lfsr_d   = lfsr_q;
    meas_d   = meas_q;
    omode_d  = omode_q;
    acc_d    = acc_q;
    tmp_d    = tmp_q;
    am_d     = am_q;
    sq_d     = sq_q;
    esum_d   = esum_q;
    err_d    = err_q;
    ov_d     = ov_q;
    olast_d  = olast_q;
    oel_d    = oel_q;
    oval_d   = oval_q;
    mom_we   = 1'b0;
    mom_wd   = '0;
    dlt_we   = 1'b0;
    dlt_wd   = dlt_new;
    w_we     = 1'b0;
    w_wd     = sat32(48'(w_rd) + 48'(mul_q));
    x_we     = 1'b0;
    t_we     = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    div_req  = '0;

    case (state_q)
      // Loads go to the staging registers; a commit picks a slot.
      ST_IDLE: begin
        if (in_acc && in_func == FN_COMMIT) begin
          k_d = '0;
          if (fill_q < ns) begin
            slot_d  = fill_q[MEM_W-1:0];
            fill_d  = fill_q + 5'd1;
            state_d = ST_STORE;
          end else begin
            lfsr_d           = lfsr_nx;
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(lfsr_nx);
            div_req.divisor  = ns;
            state_d          = ST_SLOT;
          end
        end
      end

      ST_SLOT: begin
        if (div_rsp.done) begin
          slot_d  = div_rsp.rem[MEM_W-1:0];
          state_d = ST_STORE;
        end
      end

      // Copy the staged sample into its slot, one element a cycle.
      ST_STORE: begin
        x_we = 1'b1;
        t_we = (k_q < IN_W'(OUT_MAX));
        k_d  = k_q + 1'b1;
        i_d   = '0;
        j_d   = '0;
        m_d   = '0;
        e_d   = '0;
        acc_d = '0;
        if (k_q == IN_W'(IN_MAX - 1)) begin
          state_d = ST_FWD_RD;
          if (epochs_q == '0) begin
            err_d   = '0;
            omode_d = 1'b1;
          end else begin
            meas_d  = 1'b0;
            omode_d = 1'b0;
          end
        end
      end

      // Dot product of a weight row with the sample or the query.
      ST_FWD_RD: state_d = ST_FWD_MUL;

      ST_FWD_MUL: begin
        mul_a   = w_rd;
        mul_b   = omode_q ? qry_q[i_q] : x_rd_q;
        state_d = ST_FWD_ACC;
      end

      ST_FWD_ACC: begin
        acc_d = acc_q + ACC_W'(mul_q);
        if (last_i) begin
          if (omode_q) begin
            ov_d    = 1'b1;
            oel_d   = j_q;
            olast_d = last_j;
            oval_d  = sat32(48'(acc_q) + 48'(mul_q));
            state_d = ST_OUT;
          end else begin
            state_d = ST_DELTA;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_FWD_RD;
        end
      end

      ST_DELTA: begin
        dlt_we  = 1'b1;
        state_d = ST_MOM_A;
      end

      // Momentum: beta*m + (1-beta)*delta.
      ST_MOM_A: begin
        mul_a   = beta;
        mul_b   = mom_q[j_q];
        state_d = ST_MOM_B;
      end

      ST_MOM_B: begin
        tmp_d   = mul_q;
        mul_a   = one_m_beta;
        mul_b   = dlt_q[j_q];
        state_d = ST_MOM_C;
      end

      ST_MOM_C: begin
        mom_we = 1'b1;
        mom_wd = sat32(48'(tmp_q) + 48'(mul_q));
        i_d    = '0;
        acc_d  = '0;
        if (last_j) begin
          j_d     = '0;
          state_d = ST_AM_MUL;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_FWD_RD;
        end
      end

      // Weight update: W += (alpha*m)*x.
      ST_AM_MUL: begin
        mul_a   = alpha;
        mul_b   = mom_q[j_q];
        state_d = ST_AM_LOAD;
      end

      ST_AM_LOAD: begin
        am_d    = mul_q;
        state_d = ST_UPD_RD;
      end

      ST_UPD_RD: state_d = ST_UPD_MUL;

      ST_UPD_MUL: begin
        mul_a   = am_q;
        mul_b   = x_rd_q;
        state_d = ST_UPD_WR;
      end

      ST_UPD_WR: begin
        w_we = 1'b1;
        if (!last_i) begin
          i_d     = i_q + 1'b1;
          state_d = ST_UPD_RD;
        end else if (!last_j) begin
          i_d     = '0;
          j_d     = j_q + 1'b1;
          state_d = ST_AM_MUL;
        end else begin
          i_d   = '0;
          j_d   = '0;
          acc_d = '0;
          if (meas_q) begin
            sq_d    = '0;
            state_d = ST_NORM_MUL;
          end else begin
            state_d = ST_FWD_RD;
            if (last_m) begin
              m_d = '0;
              e_d = e_q + 4'd1;
              if (last_e) begin
                meas_d = 1'b1;
                esum_d = '0;
              end
            end else begin
              m_d = m_q + 1'b1;
            end
          end
        end
      end

      // Error pass: squared delta norm, then its root.
      ST_NORM_MUL: begin
        mul_a   = dlt_q[j_q];
        mul_b   = dlt_q[j_q];
        state_d = ST_NORM_ACC;
      end

      ST_NORM_ACC: begin
        sq_d = sq_sum[64] ? '1 : sq_sum[63:0];
        if (last_j) begin
          state_d = ST_ROOT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_NORM_MUL;
        end
      end

      ST_ROOT: begin
        sq_start = root_go_q;
        if (sq_done) begin
          esum_d = esum_nx;
          j_d    = '0;
          i_d    = '0;
          acc_d  = '0;
          if (last_m) begin
            div_req.start    = 1'b1;
            div_req.dividend = esum_nx;
            div_req.divisor  = fill_q;
            state_d          = ST_MEAN;
          end else begin
            m_d     = m_q + 1'b1;
            state_d = ST_FWD_RD;
          end
        end
      end

      ST_MEAN: begin
        if (div_rsp.done) begin
          err_d   = (div_rsp.quot > DIV_W'(31'h7fffffff)) ? 31'h7fffffff
                                                         : div_rsp.quot[30:0];
          omode_d = 1'b1;
          j_d     = '0;
          i_d     = '0;
          acc_d   = '0;
          state_d = ST_FWD_RD;
        end
      end

      // Hold each result until it is taken.
      ST_OUT: begin
        if (m_axis_tready_i) begin
          ov_d  = 1'b0;
          i_d   = '0;
          acc_d = '0;
          if (olast_q) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_FWD_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // The root unit starts once, on the cycle the norm sum is complete.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_go_q <= 1'b0;
    end else begin
      root_go_q <= (state_q == ST_NORM_ACC) && last_j;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      m_q     <= '0;
      slot_q  <= '0;
      e_q     <= '0;
      k_q     <= '0;
      fill_q  <= '0;
      lfsr_q  <= LFSR_SEED;
      meas_q  <= 1'b0;
      omode_q <= 1'b0;
      ov_q    <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      m_q     <= m_d;
      slot_q  <= slot_d;
      e_q     <= e_d;
      k_q     <= k_d;
      fill_q  <= fill_d;
      lfsr_q  <= lfsr_d;
      meas_q  <= meas_d;
      omode_q <= omode_d;
      ov_q    <= ov_d;
      olast_q <= olast_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    tmp_q  <= tmp_d;
    am_q   <= am_d;
    sq_q   <= sq_d;
    esum_q <= esum_d;
    oel_q  <= oel_d;
    oval_q <= oval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
    end else begin
      err_q <= err_d;
    end
  end

  // Staging, query, momentum and delta registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < IN_MAX; n++) begin
        stg_in_q[n] <= '0;
        qry_q[n]    <= '0;
      end
      for (int n = 0; n < OUT_MAX; n++) begin
        stg_tg_q[n] <= '0;
        mom_q[n]    <= '0;
        dlt_q[n]    <= '0;
      end
    end else begin
      if (in_acc && in_func == FN_LOAD_IN) begin
        stg_in_q[in_elem] <= in_value;
      end
      if (in_acc && in_func == FN_LOAD_TGT && in_elem < IN_W'(OUT_MAX)) begin
        stg_tg_q[in_elem[OUT_W-1:0]] <= in_value;
      end
      if (in_acc && in_func == FN_LOAD_QRY) begin
        qry_q[in_elem] <= in_value;
      end
      if (mom_we) begin
        mom_q[j_q] <= mom_wd;
      end
      if (dlt_we) begin
        dlt_q[j_q] <= dlt_wd;
      end
    end
  end

  // Weight memory with per-entry valid bits standing for the zero reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q   <= '0;
      w_ok_q <= 1'b0;
    end else begin
      if (w_we) begin
        wv_q[w_addr] <= 1'b1;
      end
      w_ok_q <= wv_q[w_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_addr] <= w_wd;
    end
    w_raw_q <= wmem[w_addr];
  end

  // Replay memory for sample inputs
  always_ff @(posedge clk_i) begin
    if (x_we) begin
      xmem[x_waddr] <= stg_in_q[k_q];
    end
    x_rd_q <= xmem[x_raddr];
  end

  // Replay memory for sample targets
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tmem[t_waddr] <= stg_tg_q[k_q[OUT_W-1:0]];
    end
    t_rd_q <= tmem[t_raddr];
  end

  // Result port
  logic signed [31:0] conf;
  assign conf = 32'(ONE_Q) - 32'(err_q);

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {6'd0, conf, err_q, oval_q, oel_q};

endmodule

// ===== hdl/drt_mul.sv =====
// ----------------------------------------------------------------------------
// drt_mul: shared Q16.16 multiplier
// Registers the exact product; the scaled result floors and saturates.
// ----------------------------------------------------------------------------
module drt_mul import drt_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o,
  output logic signed [31:0] q_o
);

  logic signed [63:0] prod_q;

  // One product per cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // Arithmetic shift gives the floor of the division by 65536.
  assign prod_o = prod_q;
  assign q_o    = sat32(48'(prod_q >>> 16));

endmodule

// ===== hdl/drt_div.sv =====
// ----------------------------------------------------------------------------
// drt_div: shared restoring divider
// One quotient bit per cycle; serves the slot pick and the mean error.
// ----------------------------------------------------------------------------
module drt_div import drt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W:0]   trial;
  logic             take;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    trial  = {rem_q, dvd_q[DIV_W-1]};
    take   = (trial >= {1'b0, dsr_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'(DIV_W - 1);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIV_W-2:0], take};
      rem_d = take ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hdl/drt_sqrt.sv =====
// ----------------------------------------------------------------------------
// drt_sqrt: iterative integer square root
// Floor of the root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module drt_sqrt import drt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  k_q, k_d;
  logic [63:0] v_q, v_d;
  logic [63:0] r_q, r_d;
  logic [63:0] bitv;
  logic [63:0] trial;

  // Classic digit-by-digit root, one bit pair per cycle.
  always_comb begin
    bitv   = 64'd1 << {k_q, 1'b0};
    trial  = r_q + bitv;
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    v_d    = v_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = 5'd31;
      v_d    = value_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d = v_q - trial;
        r_d = (r_q >> 1) + bitv;
      end else begin
        r_d = r_q >> 1;
      end
      k_d = k_q - 5'd1;
      if (k_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

// ===== tb/delta_rule_replay_trainer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_rule_replay_trainer_test: self-checking bench of the replay trainer
// Drives load and commit items with random gaps, and reprograms the registers
// between phases, extremes included. Every output element of a commit is
// compared with a local delta-rule model of weights, momentum and replay memory.
// ----------------------------------------------------------------------------
module delta_rule_replay_trainer_test;
  import drt_pkg::*;

  // One output element of a commit.
  typedef struct {
    bit [2:0]  elem;
    int        value;
    bit [30:0] err;
    int        conf;
    bit        last;
  } out_item_t;

  // One row of the directed part.
  typedef struct {
    func_e    fn;
    bit [3:0] el;
    int       val;
    bit       zero_out;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [39:0]  s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  delta_rule_replay_trainer dut (.*);

  always #1 clk_i = ~clk_i;

  // Model state.
  int              wts [OUT_MAX][IN_MAX];
  int              mom [OUT_MAX];
  int              dlt [OUT_MAX];
  int              mem_x [MEM_DEPTH][IN_MAX];
  int              mem_y [MEM_DEPTH][OUT_MAX];
  int              fill;
  int              stg_x [IN_MAX];
  int              stg_y [OUT_MAX];
  int              qry [IN_MAX];
  bit [15:0]       lfsr;
  int unsigned     cfg_rate, cfg_smooth, cfg_epochs, cfg_in, cfg_out, cfg_slots;

  out_item_t       expected_outs [$];
  int              fails = 0;
  int              n_items = 0;
  int              n_commits = 0;
  int              n_outs = 0;
  bit              hold_done = 1'b0;

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Q16.16 product, floored and saturated.
  function automatic int qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat(p >>> 16);
  endfunction

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int row_dot(int j, int x [IN_MAX]);
    longint acc;
    acc = 0;
    for (int i = 0; i < clampu(cfg_in, 1, IN_MAX); i++) acc += qmul(wts[j][i], x[i]);
    return sat(acc);
  endfunction

  // One delta-rule step with momentum on a stored sample.
  function automatic void learn_sample(int x [IN_MAX], int y [OUT_MAX]);
    int ni, no, alpha, beta, am;
    ni = clampu(cfg_in, 1, IN_MAX);
    no = clampu(cfg_out, 1, OUT_MAX);
    alpha = clampu(cfg_rate, 0, 65536);
    beta = clampu(cfg_smooth, 0, 65536);
    for (int j = 0; j < no; j++) begin
      dlt[j] = sat(longint'(y[j]) - row_dot(j, x));
      mom[j] = sat(longint'(qmul(beta, mom[j])) + qmul(65536 - beta, dlt[j]));
    end
    for (int j = 0; j < no; j++) begin
      am = qmul(alpha, mom[j]);
      for (int i = 0; i < ni; i++) wts[j][i] = sat(longint'(wts[j][i]) + qmul(am, x[i]));
    end
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned delta_norm();
    longint unsigned sum, a, sq;
    sum = 0;
    for (int j = 0; j < clampu(cfg_out, 1, OUT_MAX); j++) begin
      a = (dlt[j] < 0) ? longint'(-longint'(dlt[j])) : longint'(dlt[j]);
      sq = a * a;
      sum = (sum > ~64'd0 - sq) ? ~64'd0 : sum + sq;
    end
    return isqrt(sum);
  endfunction

  // Apply one accepted item to the model and queue the outputs it causes.
  function automatic void model_item(func_e fn, bit [3:0] el, int val, bit zero_out);
    int slot, ns, no;
    longint unsigned err, sum;
    out_item_t o;
    case (fn)
      FN_LOAD_IN:  begin stg_x[el] = val; return; end
      FN_LOAD_TGT: begin if (el < OUT_MAX) stg_y[el] = val; return; end
      FN_LOAD_QRY: begin qry[el] = val; return; end
      default: ;
    endcase
    ns = clampu(cfg_slots, 1, MEM_DEPTH);
    if (fill < ns) begin
      slot = fill;
      fill++;
    end else begin
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
      slot = lfsr % ns;
    end
    mem_x[slot] = stg_x;
    mem_y[slot] = stg_y;
    for (int e = 0; e < cfg_epochs; e++)
      for (int m = 0; m < fill; m++) learn_sample(mem_x[m], mem_y[m]);
    err = 0;
    if (cfg_epochs > 0 && fill > 0) begin
      sum = 0;
      for (int m = 0; m < fill; m++) begin
        learn_sample(mem_x[m], mem_y[m]);
        sum += delta_norm();
      end
      err = sum / fill;
      if (err > 64'h7fffffff) err = 64'h7fffffff;
    end
    no = clampu(cfg_out, 1, OUT_MAX);
    for (int j = 0; j < no; j++) begin
      o.elem = 3'(j);
      o.value = row_dot(j, qry);
      o.err = err[30:0];
      o.conf = 65536 - int'(err);
      o.last = (j == no - 1);
      // Rows typed in by hand: all-zero weights and samples.
      if (zero_out) begin
        o.value = 0;
        o.err = '0;
        o.conf = 65536;
      end
      expected_outs.push_back(o);
    end
    n_commits++;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(func_e fn, bit [3:0] el, int val, bit zero_out);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = fn;
    s_axis_tdata_i = {4'b0, val, el};
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_item(fn, el, val, zero_out);
    n_items++;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic reg_write(reg_e r, int unsigned v);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (r)
      RG_RATE:      cfg_rate = v & 32'h1ffff;
      RG_SMOOTHING: cfg_smooth = v & 32'h1ffff;
      RG_EPOCHS:    cfg_epochs = v & 32'hf;
      RG_IN_LEN:    cfg_in = v & 32'h1f;
      RG_OUT_LEN:   cfg_out = v & 32'hf;
      default:      cfg_slots = v & 32'h1f;
    endcase
  endtask

  // Wait for all outputs, then a pause so that no trailing load is in flight.
  task automatic drain();
    while (expected_outs.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_regs(int unsigned ra, int unsigned sm, int unsigned ep,
                          int unsigned ni, int unsigned no, int unsigned sl);
    drain();
    reg_write(RG_RATE, ra);
    reg_write(RG_SMOOTHING, sm);
    reg_write(RG_EPOCHS, ep);
    reg_write(RG_IN_LEN, ni);
    reg_write(RG_OUT_LEN, no);
    reg_write(RG_SLOTS, sl);
  endtask

  // Random items: mostly loads inside the lengths in use, about one commit in five.
  task automatic random_items(int count, bit pause_mid);
    int r, val;
    bit [3:0] el;
    func_e fn;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      fn = (r < 35) ? FN_LOAD_IN : (r < 60) ? FN_LOAD_TGT : (r < 80) ? FN_LOAD_QRY : FN_COMMIT;
      if ($urandom_range(0, 3) == 0) el = 4'($urandom_range(0, 15));
      else if (fn == FN_LOAD_TGT) el = 4'($urandom_range(0, clampu(cfg_out, 1, OUT_MAX) - 1));
      else el = 4'($urandom_range(0, clampu(cfg_in, 1, IN_MAX) - 1));
      if ($urandom_range(0, 1) == 0) val = int'($urandom_range(0, 262143)) - 131072;
      else val = $urandom;
      send_item(fn, el, val, 1'b0);
      if (pause_mid && k == count / 2) drain();
    end
  endtask

  stim_row_t directed [] = '{
    '{FN_COMMIT,   4'd0,  0,            1'b1},
    '{FN_LOAD_QRY, 4'd0,  32'h7fffffff, 1'b0},
    '{FN_LOAD_QRY, 4'd15, 32'h80000000, 1'b0},
    '{FN_COMMIT,   4'd0,  0,            1'b1},
    '{FN_LOAD_IN,  4'd0,  32'h7fffffff, 1'b0},
    '{FN_LOAD_IN,  4'd15, 32'h80000000, 1'b0},
    '{FN_LOAD_TGT, 4'd0,  32'h80000000, 1'b0},
    '{FN_LOAD_TGT, 4'd7,  32'h7fffffff, 1'b0},
    '{FN_LOAD_TGT, 4'd8,  32'h12345678, 1'b0},
    '{FN_LOAD_TGT, 4'd15, 32'hffffffff, 1'b0},
    '{FN_COMMIT,   4'd0,  0,            1'b0},
    '{FN_LOAD_IN,  4'd0,  32'h00010000, 1'b0},
    '{FN_LOAD_IN,  4'd15, 32'hffff0000, 1'b0},
    '{FN_LOAD_IN,  4'd5,  32'h00008000, 1'b0},
    '{FN_LOAD_TGT, 4'd0,  32'h00020000, 1'b0},
    '{FN_LOAD_TGT, 4'd7,  32'hfffe0000, 1'b0},
    '{FN_LOAD_QRY, 4'd5,  32'h00010000, 1'b0},
    '{FN_LOAD_QRY, 4'd0,  32'h00000000, 1'b0},
    '{FN_LOAD_QRY, 4'd15, 32'h00004000, 1'b0},
    '{FN_COMMIT,   4'd3,  32'hdeadbeef, 1'b0},
    '{FN_COMMIT,   4'd12, 0,            1'b0}
  };

  // Stimulus and phases.
  initial begin
    cfg_rate = 6554; cfg_smooth = 0; cfg_epochs = 1;
    cfg_in = 16; cfg_out = 8; cfg_slots = 16;
    fill = 0;
    lfsr = LFSR_SEED;
    foreach (wts[j, i]) wts[j][i] = 0;
    foreach (mom[j]) begin mom[j] = 0; dlt[j] = 0; stg_y[j] = 0; end
    foreach (qry[i]) begin qry[i] = 0; stg_x[i] = 0; end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[k]) send_item(directed[k].fn, directed[k].el, directed[k].val,
                                    directed[k].zero_out);

    // Extremes and out-of-range register values: no epochs, one slot.
    set_regs(32'h1ffff, 32'h1ffff, 0, 0, 15, 0);
    random_items(15, 1'b0);
    set_regs(0, 0, 1, 1, 1, 1);
    random_items(15, 1'b0);
    set_regs($urandom_range(0, 65536), $urandom_range(0, 65536), 2, 4, 3, 4);
    random_items(25, 1'b1);
    set_regs(65536, 32768, 15, 2, 2, 2);
    random_items(15, 1'b0);
    set_regs($urandom_range(0, 65536), 0, 3, 16, 8, 16);
    random_items(12, 1'b0);

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d items, %0d commits and %0d output elements", n_items,
             n_commits, n_outs);
    $display("over six register settings with random gaps and stalls on both sides.");
    if (fails == 0) begin
      $display("delta_rule_replay_trainer verification clean");
    end else begin
      $display("delta_rule_replay_trainer verification failed");
    end
    $finish;
  end

  // Output side: random readiness, plus one long hold-off after a few outputs.
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (!hold_done && n_outs >= 5) begin
        hold_done = 1'b1;
        m_axis_tready_i = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      g = pick_gap();
      if (g > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // Compare each accepted output element with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_outs++;
      if (expected_outs.size() == 0) begin
        fails++;
        $display("%0t: unexpected output element, data %h", $realtime, m_axis_tdata_o);
      end else begin
        e = expected_outs.pop_front();
        if (m_axis_tdata_o[2:0] !== e.elem) begin
          fails++;
          $display("%0t: out_elem expected %0d, got %0d", $realtime, e.elem,
                   m_axis_tdata_o[2:0]);
        end
        if (m_axis_tdata_o[34:3] !== e.value) begin
          fails++;
          $display("%0t: out_value expected %h, got %h", $realtime, e.value,
                   m_axis_tdata_o[34:3]);
        end
        if (m_axis_tdata_o[65:35] !== e.err) begin
          fails++;
          $display("%0t: mean_error expected %h, got %h", $realtime, e.err,
                   m_axis_tdata_o[65:35]);
        end
        if (m_axis_tdata_o[97:66] !== e.conf) begin
          fails++;
          $display("%0t: confidence expected %h, got %h", $realtime, e.conf,
                   m_axis_tdata_o[97:66]);
        end
        if (m_axis_tlast_o !== e.last) begin
          fails++;
          $display("%0t: last expected %b, got %b", $realtime, e.last, m_axis_tlast_o);
        end
      end
    end
  end

  // Run limit.
  initial begin
    #40000000;
    $display("delta_rule_replay_trainer verification failed");
    $finish;
  end

endmodule

// ===== delta_rule_replay_trainer.f =====
hdl/drt_pkg.sv
hdl/drt_mul.sv
hdl/drt_div.sv
hdl/drt_sqrt.sv
hdl/delta_rule_replay_trainer.sv
tb/delta_rule_replay_trainer_test.sv
